// ----- sv/ieas_pkg.sv -----
// Shared types and constants for the I2C EEPROM access sequencer.
// No dependencies; imported by every module of the block.
package ieas_pkg;

  localparam int PAGE_BYTES_DEF = 64;

  // Host and bus opcodes carried on the request channel
  typedef enum logic [2:0] {
    OP_RD_CUR   = 3'd0,
    OP_RD_RAND  = 3'd1,
    OP_WR_BYTE  = 3'd2,
    OP_WR_PAGE  = 3'd3,
    OP_RD_SEQ   = 3'd4,
    OP_PAGE_DAT = 3'd5,
    OP_BUS_DONE = 3'd6,
    OP_UNUSED   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RECV  = 3'd3,
    CMD_ACK   = 3'd4,
    CMD_NACK  = 3'd5,
    CMD_STOP  = 3'd6,
    CMD_RSVD  = 3'd7
  } bus_cmd_e;

  typedef enum logic [13:0] {
    PH_IDLE      = 14'h0001,
    PH_W_START   = 14'h0002,
    PH_W_CTRL    = 14'h0004,
    PH_W_HI      = 14'h0008,
    PH_W_LO      = 14'h0010,
    PH_W_DATA    = 14'h0020,
    PH_PAGE_WAIT = 14'h0040,
    PH_P_DATA    = 14'h0080,
    PH_R_START   = 14'h0100,
    PH_R_CTRL    = 14'h0200,
    PH_R_RECV    = 14'h0400,
    PH_R_ACK     = 14'h0800,
    PH_R_NACK    = 14'h1000,
    PH_STOP      = 14'h2000
  } phase_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] mem_address;
    logic [7:0]  data_byte;
    logic [7:0]  length;
    logic        bus_nack;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    op_e         kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  remaining;
    logic [7:0]  done_cnt;
    logic        pend_err;
  } seq_state_t;

  typedef struct packed {
    bus_cmd_e   bus_command;
    logic [7:0] tx_byte;
    logic       need_page_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       host_done;
    logic       error_flag;
    logic [7:0] byte_count;
  } result_t;

endpackage

// ----- sv/ieas_step.sv -----
// Next-state and result logic of the EEPROM access sequencer.
// Depends on ieas_pkg; instantiated by the top level.
module ieas_step
  import ieas_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  seq_state_t cur_i,
  input  item_t      item_i,
  input  logic [6:0] dev_addr_i,
  output seq_state_t nxt_o,
  output logic       hit_o,
  output result_t    res_o
);

  logic [7:0] page_clip;
  logic [7:0] rem_dec;
  logic [7:0] cnt_inc;

  assign page_clip = ({1'b0, item_i.length} > 9'(PAGE_BYTES)) ? 8'(PAGE_BYTES)
                                                              : item_i.length;
  assign rem_dec = cur_i.remaining - 8'd1;
  assign cnt_inc = cur_i.done_cnt + 8'd1;

  always_comb begin
    nxt_o = cur_i;
    hit_o = 1'b0;
    res_o = '0;
    if (cur_i.phase == PH_IDLE) begin
      if (item_i.opcode inside {OP_RD_CUR, OP_RD_RAND, OP_WR_BYTE, OP_WR_PAGE, OP_RD_SEQ}) begin
        hit_o          = 1'b1;
        nxt_o.kind     = item_i.opcode;
        nxt_o.addr     = item_i.mem_address;
        nxt_o.data     = item_i.data_byte;
        nxt_o.done_cnt = '0;
        nxt_o.pend_err = 1'b0;
        case (item_i.opcode)
          OP_WR_PAGE: nxt_o.remaining = page_clip;
          OP_RD_SEQ:  nxt_o.remaining = item_i.length;
          default:    nxt_o.remaining = 8'd1;
        endcase
        nxt_o.phase       = (item_i.opcode == OP_RD_CUR) ? PH_R_START : PH_W_START;
        res_o.bus_command = CMD_START;
      end
    end else if (cur_i.phase == PH_PAGE_WAIT) begin
      if (item_i.opcode == OP_PAGE_DAT) begin
        hit_o             = 1'b1;
        nxt_o.phase       = PH_P_DATA;
        res_o.bus_command = CMD_SEND;
        res_o.tx_byte     = item_i.data_byte;
      end
    end else if (item_i.opcode == OP_BUS_DONE) begin
      hit_o = 1'b1;
      case (cur_i.phase)
        PH_W_START: begin
          nxt_o.phase       = PH_W_CTRL;
          res_o.bus_command = CMD_SEND;
          res_o.tx_byte     = {dev_addr_i, 1'b0};
        end
        PH_W_CTRL: begin
          if (item_i.bus_nack) begin
            nxt_o.phase       = PH_W_START;
            res_o.bus_command = CMD_START;
          end else begin
            nxt_o.phase       = PH_W_HI;
            res_o.bus_command = CMD_SEND;
            res_o.tx_byte     = cur_i.addr[15:8];
          end
        end
        PH_W_HI: begin
          if (item_i.bus_nack) begin
            nxt_o.pend_err    = 1'b1;
            nxt_o.phase       = PH_STOP;
            res_o.bus_command = CMD_STOP;
          end else begin
            nxt_o.phase       = PH_W_LO;
            res_o.bus_command = CMD_SEND;
            res_o.tx_byte     = cur_i.addr[7:0];
          end
        end
        PH_W_LO: begin
          if (item_i.bus_nack) begin
            nxt_o.pend_err    = 1'b1;
            nxt_o.phase       = PH_STOP;
            res_o.bus_command = CMD_STOP;
          end else if (cur_i.kind == OP_WR_BYTE) begin
            nxt_o.phase       = PH_W_DATA;
            res_o.bus_command = CMD_SEND;
            res_o.tx_byte     = cur_i.data;
          end else if (cur_i.kind == OP_WR_PAGE) begin
            if (cur_i.remaining == '0) begin
              nxt_o.phase       = PH_STOP;
              res_o.bus_command = CMD_STOP;
            end else begin
              nxt_o.phase          = PH_PAGE_WAIT;
              res_o.need_page_byte = 1'b1;
            end
          end else begin
            // random and sequential reads: repeated start for the read phase
            nxt_o.phase       = PH_R_START;
            res_o.bus_command = CMD_START;
          end
        end
        PH_W_DATA: begin
          if (item_i.bus_nack) nxt_o.pend_err = 1'b1;
          else                 nxt_o.done_cnt = 8'd1;
          nxt_o.phase       = PH_STOP;
          res_o.bus_command = CMD_STOP;
        end
        PH_P_DATA: begin
          if (item_i.bus_nack) begin
            nxt_o.pend_err    = 1'b1;
            nxt_o.phase       = PH_STOP;
            res_o.bus_command = CMD_STOP;
          end else begin
            nxt_o.done_cnt  = cnt_inc;
            nxt_o.remaining = rem_dec;
            if (rem_dec == '0) begin
              nxt_o.phase       = PH_STOP;
              res_o.bus_command = CMD_STOP;
            end else begin
              nxt_o.phase          = PH_PAGE_WAIT;
              res_o.need_page_byte = 1'b1;
            end
          end
        end
        PH_R_START: begin
          nxt_o.phase       = PH_R_CTRL;
          res_o.bus_command = CMD_SEND;
          res_o.tx_byte     = {dev_addr_i, 1'b1};
        end
        PH_R_CTRL: begin
          if (item_i.bus_nack) begin
            nxt_o.phase       = PH_R_START;
            res_o.bus_command = CMD_START;
          end else if (cur_i.remaining == '0) begin
            nxt_o.phase       = PH_STOP;
            res_o.bus_command = CMD_STOP;
          end else begin
            nxt_o.phase       = PH_R_RECV;
            res_o.bus_command = CMD_RECV;
          end
        end
        PH_R_RECV: begin
          nxt_o.done_cnt   = cnt_inc;
          nxt_o.remaining  = rem_dec;
          res_o.read_valid = 1'b1;
          res_o.read_byte  = item_i.rx_byte;
          if (rem_dec == '0) begin
            nxt_o.phase       = PH_R_NACK;
            res_o.bus_command = CMD_NACK;
          end else begin
            nxt_o.phase       = PH_R_ACK;
            res_o.bus_command = CMD_ACK;
          end
        end
        PH_R_ACK: begin
          nxt_o.phase       = PH_R_RECV;
          res_o.bus_command = CMD_RECV;
        end
        PH_R_NACK: begin
          nxt_o.phase       = PH_STOP;
          res_o.bus_command = CMD_STOP;
        end
        PH_STOP: begin
          nxt_o.phase      = PH_IDLE;
          res_o.host_done  = 1'b1;
          res_o.error_flag = cur_i.pend_err;
          res_o.byte_count = cur_i.done_cnt;
        end
        default: begin
          nxt_o.phase = PH_IDLE;
          hit_o       = 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/i2c_eeprom_access_sequencer_top.sv -----
// I2C EEPROM access sequencer: top level with request/result registers.
// Depends on ieas_pkg and ieas_step.
// A request passes the request register, then the result register, before its
// result shows. Throughput: one request per cycle while the result register is
// not stalled; the sequencer state loop through ieas_step is combinational into st_q.
// Reset (async, active low): phase idle, counters and flags cleared, device
// address 80, both pipeline registers empty.
module i2c_eeprom_access_sequencer_top
  import ieas_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [15:0] mem_address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  length_i,
  input  logic        bus_nack_i,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  bus_command_o,
  output logic [7:0]  tx_byte_o,
  output logic        need_page_byte_o,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o,
  output logic        host_done_o,
  output logic        error_flag_o,
  output logic [7:0]  byte_count_o,
  output logic        last_result_o
);

  logic [6:0] dev_addr_q;

  logic       in_vld_q;
  item_t      in_item_q;

  seq_state_t st_q, st_d;
  logic       res_hit;
  result_t    res;

  logic       out_vld_q;
  result_t    out_res_q;

  // The request stage moves whenever the result register is free or drains.
  logic advance;
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 7'd80;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= '{opcode:      op_e'(opcode_i),
                     mem_address: mem_address_i,
                     data_byte:   data_byte_i,
                     length:      length_i,
                     bus_nack:    bus_nack_i,
                     rx_byte:     rx_byte_i};
    end
  end

  ieas_step #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_step (
    .cur_i     (st_q),
    .item_i    (in_item_q),
    .dev_addr_i(dev_addr_q),
    .nxt_o     (st_d),
    .hit_o     (res_hit),
    .res_o     (res)
  );

  // Sequencer state advances once per request leaving the request stage;
  // ignored requests leave it unchanged apart from the default recovery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, kind: OP_RD_CUR, default: '0};
    end else if (in_vld_q && advance) begin
      st_q <= st_d;
    end
  end

  // Result register; requests that cause no result drop out here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q && res_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign bus_command_o    = out_res_q.bus_command;
  assign tx_byte_o        = out_res_q.tx_byte;
  assign need_page_byte_o = out_res_q.need_page_byte;
  assign read_valid_o     = out_res_q.read_valid;
  assign read_byte_o      = out_res_q.read_byte;
  assign host_done_o      = out_res_q.host_done;
  assign error_flag_o     = out_res_q.error_flag;
  assign byte_count_o     = out_res_q.byte_count;
  // every request causes at most one result
  assign last_result_o    = 1'b1;

endmodule

// ----- sv/ieas_checker.sv -----
// Port-level checks for the I2C EEPROM access sequencer, bound to the top.
// Depends on ieas_pkg and i2c_eeprom_access_sequencer_top.
module ieas_checker
  import ieas_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] bus_command_o,
  input logic [7:0] tx_byte_o,
  input logic       read_valid_o,
  input logic       host_done_o,
  input logic       need_page_byte_o,
  input logic       last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(bus_command_o) && $stable(tx_byte_o))
    else $error("stalled result changed");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (host_done_o || need_page_byte_o) |-> bus_command_o == CMD_NONE)
    else $error("done or page request carries a bus command");

  a_read_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> bus_command_o == CMD_ACK || bus_command_o == CMD_NACK)
    else $error("read byte without ack or nack");

  a_tx_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_command_o != CMD_SEND |-> tx_byte_o == 8'd0 && last_result_o)
    else $error("tx byte set without send");

endmodule

bind i2c_eeprom_access_sequencer_top ieas_checker u_ieas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .bus_command_o   (bus_command_o),
  .tx_byte_o       (tx_byte_o),
  .read_valid_o    (read_valid_o),
  .host_done_o     (host_done_o),
  .need_page_byte_o(need_page_byte_o),
  .last_result_o   (last_result_o)
);

// ----- tb/tb_i2c_eeprom_access_sequencer_top.sv -----
// Self-checking testbench for i2c_eeprom_access_sequencer_top: directed table, then
// protocol-aware random requests checked against a cycle-free behavioral predictor.
// Depends on ieas_pkg and the sequencer RTL; reads no files.
`timescale 1ns / 100ps

module tb_i2c_eeprom_access_sequencer_top;
  import ieas_pkg::*;

  localparam int PAGE_LIMIT = PAGE_BYTES_DEF;

  // How a request's result is checked
  typedef enum logic [1:0] {
    CHK_IGNORED,  // block must not answer
    CHK_TYPED,    // answer typed into the table
    CHK_PREDICT   // answer from the predictor
  } check_e;

  typedef struct {
    item_t   req;
    check_e  chk;
    result_t want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [15:0] mem_address_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  length_i = '0;
  logic        bus_nack_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  bus_command_o;
  logic [7:0]  tx_byte_o;
  logic        need_page_byte_o;
  logic        read_valid_o;
  logic [7:0]  read_byte_o;
  logic        host_done_o;
  logic        error_flag_o;
  logic [7:0]  byte_count_o;
  logic        last_result_o;

  i2c_eeprom_access_sequencer_top #(
    .PAGE_BYTES(PAGE_LIMIT)
  ) dut (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the sequencer as of every accepted request
  // ---------------------------------------------------------------------------
  phase_e      ph = PH_IDLE;
  op_e         kind = OP_RD_CUR;
  logic [15:0] addr_q = '0;
  logic [7:0]  data_q = '0;
  logic [7:0]  remain_q = '0;
  logic [7:0]  count_q = '0;
  logic        err_q = 1'b0;
  logic [6:0]  dev_q = 7'd80;

  result_t     expected_results[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatches = 0;
  bit          gaps_on = 1'b1;   // sender idles in bursts
  bit          stall_on = 1'b1;  // receiver stalls in bursts
  int unsigned stall_left = 0;

  function automatic result_t cmd_res(bus_cmd_e c, logic [7:0] tx);
    result_t r;
    r = '0;
    r.bus_command = c;
    r.tx_byte = tx;
    return r;
  endfunction

  function automatic result_t read_res(bus_cmd_e c, logic [7:0] b);
    result_t r;
    r = cmd_res(c, 8'h00);
    r.read_valid = 1'b1;
    r.read_byte = b;
    return r;
  endfunction

  function automatic result_t done_res(logic err, logic [7:0] cnt);
    result_t r;
    r = cmd_res(CMD_NONE, 8'h00);
    r.host_done = 1'b1;
    r.error_flag = err;
    r.byte_count = cnt;
    return r;
  endfunction

  function automatic result_t page_req_res();
    result_t r;
    r = cmd_res(CMD_NONE, 8'h00);
    r.need_page_byte = 1'b1;
    return r;
  endfunction

  // Every path into the stop phase goes through here; errors stick until done.
  function automatic result_t stop_res(logic with_err);
    if (with_err) err_q = 1'b1;
    ph = PH_STOP;
    return cmd_res(CMD_STOP, 8'h00);
  endfunction

  // Advances the predictor by one accepted request. Returns 1 when the block
  // answers it, with the answer in r; 0 when the request is dropped.
  function automatic bit sequence_step(input item_t it, output result_t r);
    r = '0;
    // Idle: only host commands start anything, the rest is dropped
    if (ph == PH_IDLE) begin
      if (it.opcode > OP_RD_SEQ) return 1'b0;
      kind = it.opcode;
      addr_q = it.mem_address;
      data_q = it.data_byte;
      count_q = '0;
      err_q = 1'b0;
      if (it.opcode == OP_WR_PAGE) begin
        remain_q = (it.length > PAGE_LIMIT) ? 8'(PAGE_LIMIT) : it.length;
      end else if (it.opcode == OP_RD_SEQ) begin
        remain_q = it.length;
      end else begin
        remain_q = 8'd1;
      end
      ph = (it.opcode == OP_RD_CUR) ? PH_R_START : PH_W_START;
      r = cmd_res(CMD_START, 8'h00);
      return 1'b1;
    end
    // Waiting on the host for a page byte: bus completions are stray here
    if (ph == PH_PAGE_WAIT) begin
      if (it.opcode != OP_PAGE_DAT) return 1'b0;
      ph = PH_P_DATA;
      r = cmd_res(CMD_SEND, it.data_byte);
      return 1'b1;
    end
    if (it.opcode != OP_BUS_DONE) return 1'b0;
    case (ph)
      PH_W_START: begin
        ph = PH_W_CTRL;
        r = cmd_res(CMD_SEND, {dev_q, 1'b0});
      end
      PH_W_CTRL: begin
        // control byte NACK: the start is retried forever
        if (it.bus_nack) begin
          ph = PH_W_START;
          r = cmd_res(CMD_START, 8'h00);
        end else begin
          ph = PH_W_HI;
          r = cmd_res(CMD_SEND, addr_q[15:8]);
        end
      end
      PH_W_HI: begin
        if (it.bus_nack) begin
          r = stop_res(1'b1);
        end else begin
          ph = PH_W_LO;
          r = cmd_res(CMD_SEND, addr_q[7:0]);
        end
      end
      PH_W_LO: begin
        if (it.bus_nack) begin
          r = stop_res(1'b1);
        end else if (kind == OP_WR_BYTE) begin
          ph = PH_W_DATA;
          r = cmd_res(CMD_SEND, data_q);
        end else if (kind == OP_WR_PAGE) begin
          if (remain_q == 0) begin
            r = stop_res(1'b0);
          end else begin
            ph = PH_PAGE_WAIT;
            r = page_req_res();
          end
        end else begin
          // random / sequential read: repeated start into the read phase
          ph = PH_R_START;
          r = cmd_res(CMD_START, 8'h00);
        end
      end
      PH_W_DATA: begin
        if (!it.bus_nack) count_q = 8'd1;
        r = stop_res(it.bus_nack);
      end
      PH_P_DATA: begin
        if (it.bus_nack) begin
          r = stop_res(1'b1);
        end else begin
          count_q = count_q + 8'd1;
          remain_q = remain_q - 8'd1;
          if (remain_q == 0) begin
            r = stop_res(1'b0);
          end else begin
            ph = PH_PAGE_WAIT;
            r = page_req_res();
          end
        end
      end
      PH_R_START: begin
        ph = PH_R_CTRL;
        r = cmd_res(CMD_SEND, {dev_q, 1'b1});
      end
      PH_R_CTRL: begin
        if (it.bus_nack) begin
          ph = PH_R_START;
          r = cmd_res(CMD_START, 8'h00);
        end else if (remain_q == 0) begin
          r = stop_res(1'b0);
        end else begin
          ph = PH_R_RECV;
          r = cmd_res(CMD_RECV, 8'h00);
        end
      end
      PH_R_RECV: begin
        // last byte is NACKed, every earlier one ACKed
        count_q = count_q + 8'd1;
        remain_q = remain_q - 8'd1;
        if (remain_q == 0) begin
          ph = PH_R_NACK;
          r = read_res(CMD_NACK, it.rx_byte);
        end else begin
          ph = PH_R_ACK;
          r = read_res(CMD_ACK, it.rx_byte);
        end
      end
      PH_R_ACK: begin
        ph = PH_R_RECV;
        r = cmd_res(CMD_RECV, 8'h00);
      end
      PH_R_NACK: begin
        r = stop_res(1'b0);
      end
      PH_STOP: begin
        ph = PH_IDLE;
        r = done_res(err_q, count_q);
      end
      default: begin
        ph = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < 50)
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result channel: each accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", bus_command_o, 0);
      end else begin
        want = expected_results.pop_front();
        if (bus_command_o !== want.bus_command)
          report_mismatch("bus_command", bus_command_o, want.bus_command);
        if (tx_byte_o !== want.tx_byte)
          report_mismatch("tx_byte", tx_byte_o, want.tx_byte);
        if (need_page_byte_o !== want.need_page_byte)
          report_mismatch("need_page_byte", need_page_byte_o, want.need_page_byte);
        if (read_valid_o !== want.read_valid)
          report_mismatch("read_valid", read_valid_o, want.read_valid);
        if (read_byte_o !== want.read_byte)
          report_mismatch("read_byte", read_byte_o, want.read_byte);
        if (host_done_o !== want.host_done)
          report_mismatch("host_done", host_done_o, want.host_done);
        if (error_flag_o !== want.error_flag)
          report_mismatch("error_flag", error_flag_o, want.error_flag);
        if (byte_count_o !== want.byte_count)
          report_mismatch("byte_count", byte_count_o, want.byte_count);
        // one result per request, so every result closes its request
        if (last_result_o !== 1'b1)
          report_mismatch("last_result", last_result_o, 1);
      end
    end
  end

  // Receiver back-pressure: random stall bursts, off when stall_on drops.
  always @(posedge clk_i) begin
    if (!stall_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Presents one request, holds it through stalls, and books its expectation at
  // the accepting edge. Returns at that edge with valid still high, so a
  // following request goes out back to back without touching valid twice.
  task automatic push_request(input item_t it, input check_e chk, input result_t typed,
                              output bit produced);
    result_t pred;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    opcode_i      <= it.opcode;
    mem_address_i <= it.mem_address;
    data_byte_i   <= it.data_byte;
    length_i      <= it.length;
    bus_nack_i    <= it.bus_nack;
    rx_byte_i     <= it.rx_byte;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = sequence_step(it, pred);
    case (chk)
      CHK_TYPED:   expected_results.push_back(typed);
      CHK_PREDICT: if (produced) expected_results.push_back(pred);
      default: ;
    endcase
  endtask

  // Device address may only change with the sequencer idle and drained. Dropped
  // requests leave nothing to wait on, so also let the two-stage pipe empty.
  task automatic write_device_address(logic [6:0] value);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_q = value;
  endtask

  function automatic void add_row(op_e op, logic [15:0] a, logic [7:0] d, logic [7:0] len,
                                  logic nack, logic [7:0] rx, check_e chk, result_t want);
    dir_row_t row;
    row.req.opcode      = op;
    row.req.mem_address = a;
    row.req.data_byte   = d;
    row.req.length      = len;
    row.req.bus_nack    = nack;
    row.req.rx_byte     = rx;
    row.chk  = chk;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  // Mostly well-formed traffic steered by the predicted phase: host commands
  // when idle, page bytes when asked, bus completions otherwise. A slice of
  // requests is pure noise, which lands on the busy and stray cases.
  function automatic item_t random_request();
    item_t       it;
    int unsigned roll;
    it.opcode      = op_e'(3'($urandom_range(0, 7)));
    it.mem_address = 16'($urandom);
    it.data_byte   = 8'($urandom);
    it.length      = 8'($urandom);
    it.bus_nack    = 1'($urandom);
    it.rx_byte     = 8'($urandom);
    if ($urandom_range(0, 99) < 8) return it;
    case (ph)
      PH_IDLE: begin
        it.opcode = op_e'(3'($urandom_range(0, 4)));
        // short counts keep commands brief; a few long ones hit clipping
        roll = $urandom_range(0, 99);
        if (roll < 70) it.length = 8'($urandom_range(0, 4));
        else if (roll < 96) it.length = 8'($urandom_range(0, 70));
      end
      PH_PAGE_WAIT: it.opcode = OP_PAGE_DAT;
      PH_W_CTRL, PH_R_CTRL: begin
        it.opcode = OP_BUS_DONE;
        it.bus_nack = ($urandom_range(0, 99) < 15);
      end
      PH_W_HI, PH_W_LO, PH_W_DATA, PH_P_DATA: begin
        it.opcode = OP_BUS_DONE;
        it.bus_nack = ($urandom_range(0, 99) < 6);
      end
      default: it.opcode = OP_BUS_DONE;
    endcase
    return it;
  endfunction

  // Runs random traffic until the given number of answered requests is
  // reached and the sequencer is back to idle.
  task automatic run_random(int unsigned answered);
    item_t       it;
    bit          produced;
    int unsigned seen;
    seen = 0;
    while (!(ph == PH_IDLE && seen >= answered)) begin
      it = random_request();
      push_request(it, CHK_PREDICT, '0, produced);
      if (produced) seen++;
    end
  endtask

  initial begin
    bit produced;

    // Directed table, device address at its reset value 80 (control bytes A0/A1).
    // Current read with one control NACK retry, single byte NACKed then stop.
    add_row(OP_RD_CUR,   16'h1234, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_START, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_SEND, 8'hA1));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, CHK_TYPED,
            cmd_res(CMD_START, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_SEND, 8'hA1));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_RECV, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'hFF, CHK_TYPED,
            read_res(CMD_NACK, 8'hFF));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_STOP, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            done_res(1'b0, 8'd1));
    // Stray page data, unused opcode and stray bus done while idle
    add_row(OP_PAGE_DAT, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, CHK_IGNORED, '0);
    add_row(OP_UNUSED,   16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, CHK_IGNORED, '0);
    add_row(OP_BUS_DONE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, CHK_IGNORED, '0);
    // Zero-length page write at the top address, with a busy host command and
    // stray page data mixed in
    add_row(OP_WR_PAGE,  16'hFFFF, 8'hFF, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_START, 8'h00));
    add_row(OP_RD_SEQ,   16'h5555, 8'h00, 8'hFF, 1'b0, 8'h00, CHK_IGNORED, '0);
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, CHK_TYPED,
            cmd_res(CMD_SEND, 8'hA0));
    add_row(OP_PAGE_DAT, 16'h0000, 8'h77, 8'h00, 1'b0, 8'h00, CHK_IGNORED, '0);
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_PREDICT, '0);
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_PREDICT, '0);
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_STOP, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, CHK_TYPED,
            done_res(1'b0, 8'd0));
    // Byte write at address zero, NACK on the high address byte
    add_row(OP_WR_BYTE,  16'h0000, 8'hFF, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_START, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_SEND, 8'hA0));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            cmd_res(CMD_SEND, 8'h00));
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b1, 8'h00, CHK_TYPED,
            cmd_res(CMD_STOP, 8'h00));
    add_row(OP_RD_RAND,  16'hABCD, 8'h00, 8'h00, 1'b0, 8'h00, CHK_IGNORED, '0);
    add_row(OP_BUS_DONE, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, CHK_TYPED,
            done_res(1'b1, 8'd0));

    // Reset: held low from time zero, released once
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      push_request(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].want,
                   produced);

    // Random phases, each under its own device address: both extremes first
    write_device_address(7'h7F);
    run_random(400);
    write_device_address(7'h00);
    run_random(400);
    write_device_address(7'($urandom));
    run_random(350);
    // last stretch runs flat out: no sender gaps, no receiver stalls
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    write_device_address(7'($urandom));
    run_random(350);

    // Drain, then wait for anything extra the pipe might still emit
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: 10 ms is many times the slowest legal run
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ieas_pkg.sv
sv/ieas_step.sv
sv/i2c_eeprom_access_sequencer_top.sv
sv/ieas_checker.sv
tb/tb_i2c_eeprom_access_sequencer_top.sv
